[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked property, skipped while reset is asserted
`define ASSERT_CLKRST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// checked property, also during reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLKRST(lbl, clk, rstn, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

[rtl/olist_pkg.sv]
// ----------------------------------------------------------------------------
// olist_pkg
// types and constants shared by the ordered list engine
// ----------------------------------------------------------------------------
`default_nettype none

package olist_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ELEM_W    = 32;
    localparam int POS_W     = 5;
    localparam int CNT_OUT_W = 5;
    localparam int STAT_W    = 3;
    localparam int FUNC_W    = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_FRONT = 2'd0,
        FN_INS_REAR  = 2'd1,
        FN_DELETE    = 2'd2,
        FN_READ      = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic              shift_in;
        logic              put_rear;
        logic              shift_out;
        logic              is_delete;
        logic [ELEM_W-1:0] new_element;
        logic [ELEM_W-1:0] search_key;
        logic [POS_W-1:0]  position;
    } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/olist_cell.sv]
// ----------------------------------------------------------------------------
// olist_cell
// one list slot: holds an element, compares it against the key and shifts
// toward either neighbor
// ----------------------------------------------------------------------------
`default_nettype none

module olist_cell
    import olist_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  wire logic                         aclk,
    input  wire cell_ctl_t                    ctl,
    input  wire logic [$clog2(DEPTH+1)-1:0]   count,
    input  wire logic [ELEM_W-1:0]            left_data,
    input  wire logic [ELEM_W-1:0]            right_data,
    input  wire logic                         hit_upto,
    input  wire logic                         hit_before,
    output logic      [ELEM_W-1:0]            data,
    output logic                              match,
    output logic      [ELEM_W-1:0]            pick_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] SLOT_IDX = CW'(IDX);
    localparam logic [PW-1:0] SLOT_POS = PW'(IDX + 1);

    logic [ELEM_W-1:0] data_reg;
    logic [ELEM_W-1:0] data_next;
    logic              occupied;
    logic              pick;

    assign occupied = SLOT_IDX < count;
    assign match    = occupied && (data_reg == ctl.search_key);

    // delete takes the first matching slot, read takes the addressed slot
    assign pick      = ctl.is_delete ? (match && !hit_before)
                                     : (SLOT_POS == PW'(ctl.position));
    assign pick_data = pick ? data_reg : '0;
    assign data      = data_reg;

    always_comb begin
        data_next = data_reg;
        if (ctl.shift_in) begin
            data_next = left_data;
        end else if (ctl.put_rear && (count == SLOT_IDX)) begin
            data_next = ctl.new_element;
        end else if (ctl.shift_out && hit_upto) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

[rtl/olist_prefix.sv]
// ----------------------------------------------------------------------------
// olist_prefix
// parallel prefix or over the cell match flags
// ----------------------------------------------------------------------------
`default_nettype none

module olist_prefix
    import olist_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic [DEPTH-1:0] match,
    output logic      [DEPTH-1:0] hit_upto
);

    localparam int LVL = $clog2(DEPTH);

    // bit i ends up set when any slot at or below i matched
    always_comb begin
        logic [DEPTH-1:0] p;
        p = match;
        for (int l = 0; l < LVL; l++) begin
            p = p | (p << (1 << l));
        end
        hit_upto = p;
    end

endmodule

`default_nettype wire

[rtl/ordered_list_engine_unit.sv]
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// bounded ordered list with insert front/rear, delete by key, read by position
// ----------------------------------------------------------------------------
// Every request is handled at its accepting edge: there the row of
// DEPTH cells, which has compared all stored elements and prepared the shift
// in parallel, updates, and the result is loaded into the output register at
// that same edge and offered on m_tvalid in the following cycle. A new request
// is taken every cycle as long as the result register is empty or being
// drained, so the sustained rate is one request per cycle; the longest path
// is the key compare followed by the log2(DEPTH)-level first-match prefix in
// olist_prefix.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine_unit
    import olist_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] new_element, [63:32] search_key, [68:64] position, [71:69] zero
    input  wire logic [71:0] s_tdata,
    // [1:0] func
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [2:0] status, [34:3] element_out, [39:35] element_count
    output logic      [39:0] m_tdata
);

    `include "assert_macros.svh"

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    func_t             func;
    logic [ELEM_W-1:0] new_element;
    logic [ELEM_W-1:0] search_key;
    logic [POS_W-1:0]  position;
    logic              accept;

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    status_t           status_reg;
    status_t           status_next;
    logic [ELEM_W-1:0] elem_reg;
    logic [ELEM_W-1:0] elem_next;
    logic [CNT_OUT_W-1:0] cnt_out_reg;

    cell_ctl_t         ctl;
    logic [ELEM_W-1:0] cell_data [DEPTH];
    logic [ELEM_W-1:0] cell_pick [DEPTH];
    logic [DEPTH-1:0]  cell_match;
    logic [DEPTH-1:0]  hit_upto;
    logic              any_hit;
    logic              full;
    logic              empty;
    logic [ELEM_W-1:0] pick_or;

    assign func        = func_t'(s_tuser[1:0]);
    assign new_element = s_tdata[31:0];
    assign search_key  = s_tdata[63:32];
    assign position    = s_tdata[68:64];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign any_hit = hit_upto[DEPTH-1];

    assign ctl.shift_in    = accept && (func == FN_INS_FRONT) && !full;
    assign ctl.put_rear    = accept && (func == FN_INS_REAR) && !full;
    assign ctl.shift_out   = accept && (func == FN_DELETE) && any_hit;
    assign ctl.is_delete   = (func == FN_DELETE);
    assign ctl.new_element = new_element;
    assign ctl.search_key  = search_key;
    assign ctl.position    = position;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [ELEM_W-1:0] left_data;
            logic [ELEM_W-1:0] right_data;
            logic              hit_before;

            if (gi == 0) begin : g_front
                assign left_data  = new_element;
                assign hit_before = 1'b0;
            end else begin : g_inner
                assign left_data  = cell_data[gi-1];
                assign hit_before = hit_upto[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_rear
                assign right_data = cell_data[gi];
            end else begin : g_mid
                assign right_data = cell_data[gi+1];
            end

            olist_cell #(
                .DEPTH (DEPTH),
                .IDX   (gi)
            ) u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .count      (count_reg),
                .left_data  (left_data),
                .right_data (right_data),
                .hit_upto   (hit_upto[gi]),
                .hit_before (hit_before),
                .data       (cell_data[gi]),
                .match      (cell_match[gi]),
                .pick_data  (cell_pick[gi])
            );
        end
    endgenerate

    olist_prefix #(
        .DEPTH (DEPTH)
    ) u_prefix (
        .match    (cell_match),
        .hit_upto (hit_upto)
    );

    // at most one cell drives a nonzero pick
    always_comb begin
        pick_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            pick_or = pick_or | cell_pick[i];
        end
    end

    always_comb begin
        status_next = ST_OK;
        elem_next   = '0;
        count_next  = count_reg;
        case (func)
            FN_INS_FRONT, FN_INS_REAR: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    count_next = count_reg + CW'(1);
                end
            end
            FN_DELETE: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else if (!any_hit) begin
                    status_next = ST_NOTFOUND;
                end else begin
                    elem_next  = pick_or;
                    count_next = count_reg - CW'(1);
                end
            end
            FN_READ: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else if ((position == '0) || (PW'(position) > PW'(count_reg))) begin
                    status_next = ST_RANGE;
                end else begin
                    elem_next = pick_or;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg  <= status_next;
            elem_reg    <= elem_next;
            cnt_out_reg <= CNT_OUT_W'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {cnt_out_reg, elem_reg, status_reg};

    `ASSERT_CLKRST(a_count_bound, aclk, aresetn, count_reg <= FULL_CNT,
        "element count above list depth")
    `ASSERT_CLKRST(a_insert_grows, aclk, aresetn,
        (accept && (func == FN_INS_REAR || func == FN_INS_FRONT) && !full)
            |=> (count_reg == $past(count_reg) + CW'(1)),
        "accepted insert did not grow the list")
    `ASSERT_CLKRST(a_delete_empty, aclk, aresetn,
        (accept && (func == FN_DELETE) && empty) |=> (status_reg == ST_EMPTY),
        "delete on empty list not reported as empty")
    `ASSERT_CLKRST(a_bad_status_zero, aclk, aresetn,
        (m_valid_reg && (status_reg != ST_OK)) |-> (elem_reg == '0),
        "element nonzero on a refused request")

endmodule

`default_nettype wire

[tb/ordered_list_engine_unit_test.sv]
// ----------------------------------------------------------------------------
// ordered_list_engine_unit_test
// self-checking bench for the bounded ordered list engine: a shadow list
// predicts status, element and count for every request, and each result is
// compared in order while the sender idles in bursts and the receiver stalls
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine_unit_test;
    import olist_pkg::*;

    localparam int LIST_DEPTH  = DEPTH_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        status_t     status;
        logic [31:0] element;
        logic [4:0]  count;
    } list_result_t;

    typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [31:0] new_element, [63:32] search_key, [68:64] position, [71:69] zero
    logic [71:0] s_tdata = '0;
    // [1:0] func
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [2:0] status, [34:3] element_out, [39:35] element_count
    logic [39:0] m_tdata;

    // shadow copy of the list, index 0 is the front
    logic [31:0]  list_copy [LIST_DEPTH];
    int           held_count = 0;
    list_result_t expected_results[$];
    int           error_count = 0;
    int           burst_left = 0;
    bit           steady_send = 1'b0;
    rx_pattern_t  rx_pattern = RX_STEADY;
    int           rx_cycle = 0;

    ordered_list_engine_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic list_result_t apply_request(func_t op, logic [31:0] value,
                                                   logic [31:0] key, logic [4:0] pos);
        list_result_t r;
        int i;
        int hit;
        r.status  = ST_OK;
        r.element = '0;
        hit = -1;
        case (op)
            FN_INS_FRONT: begin
                if (held_count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = held_count; i > 0; i--) list_copy[i] = list_copy[i-1];
                    list_copy[0] = value;
                    held_count++;
                end
            end
            FN_INS_REAR: begin
                if (held_count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_copy[held_count] = value;
                    held_count++;
                end
            end
            FN_DELETE: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (i = 0; i < held_count && hit < 0; i++)
                        if (list_copy[i] == key) hit = i;
                    if (hit < 0) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        r.element = list_copy[hit];
                        for (i = hit; i + 1 < held_count; i++) list_copy[i] = list_copy[i+1];
                        held_count--;
                    end
                end
            end
            default: begin
                if (held_count == 0)
                    r.status = ST_EMPTY;
                else if (pos == 0 || pos > held_count)
                    r.status = ST_RANGE;
                else
                    r.element = list_copy[pos-1];
            end
        endcase
        r.count = held_count[4:0];
        return r;
    endfunction

    // mostly extremes and a small pool so that duplicates and key hits are common
    function automatic logic [31:0] pick_element();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3, 4, 5: return $urandom_range(0, 6) - 3;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_request(func_t op, logic [31:0] value, logic [31:0] key,
                                logic [4:0] pos);
        if (!steady_send && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, pos, key, value};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(apply_request(op, value, key, pos));
    endtask

    task automatic note_failure(string what, logic [39:0] exp_val, logic [39:0] got_val);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %h, got %h", what, exp_val, got_val);
    endtask

    always @(posedge aclk) begin : result_check
        list_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                note_failure("unrequested result", '0, m_tdata);
            end else begin
                exp_r = expected_results.pop_front();
                if (m_tdata[2:0] !== exp_r.status)
                    note_failure("status", 40'(exp_r.status), 40'(m_tdata[2:0]));
                if (m_tdata[34:3] !== exp_r.element)
                    note_failure("element_out", 40'(exp_r.element), 40'(m_tdata[34:3]));
                if (m_tdata[39:35] !== exp_r.count)
                    note_failure("element_count", 40'(exp_r.count), 40'(m_tdata[39:35]));
            end
        end
    end

    // receiver stall pattern, periodically redrawn at random
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 300 == 299) rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
        case (rx_pattern)
            RX_STEADY:   m_tready <= 1'b1;
            RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   m_tready <= ($urandom_range(0, 7) == 0);
            default:     m_tready <= (rx_cycle % 7) < 3;
        endcase
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("ordered_list_engine_unit_test: errors");
        $finish;
    end

    task automatic test_empty_list();
        send_request(FN_READ, $urandom(), $urandom(), 5'd1);
        send_request(FN_READ, $urandom(), $urandom(), 5'd0);
        send_request(FN_DELETE, $urandom(), 32'h0, 5'($urandom()));
    endtask

    task automatic test_edge_values();
        send_request(FN_INS_FRONT, 32'h8000_0000, $urandom(), 5'($urandom()));
        send_request(FN_INS_REAR, 32'h7fff_ffff, $urandom(), 5'($urandom()));
        send_request(FN_INS_FRONT, 32'h0, $urandom(), 5'($urandom()));
        send_request(FN_INS_REAR, 32'hffff_ffff, $urandom(), 5'($urandom()));
        send_request(FN_READ, $urandom(), $urandom(), 5'd0);
        send_request(FN_READ, $urandom(), $urandom(), 5'd1);
        send_request(FN_READ, $urandom(), $urandom(), 5'd4);
        send_request(FN_READ, $urandom(), $urandom(), 5'd5);
        send_request(FN_READ, $urandom(), $urandom(), 5'd31);
        send_request(FN_DELETE, $urandom(), 32'd12345, 5'($urandom()));
        send_request(FN_DELETE, $urandom(), 32'h8000_0000, 5'($urandom()));
        // duplicate value: only the copy nearest the front goes
        send_request(FN_INS_REAR, 32'h0, $urandom(), 5'($urandom()));
        send_request(FN_DELETE, $urandom(), 32'h0, 5'($urandom()));
        send_request(FN_READ, $urandom(), $urandom(), 5'd3);
    endtask

    task automatic test_fill_to_capacity();
        while (held_count < LIST_DEPTH)
            send_request($urandom_range(0, 1) ? FN_INS_REAR : FN_INS_FRONT,
                         $urandom(), $urandom(), 5'($urandom()));
        send_request(FN_INS_FRONT, $urandom(), $urandom(), 5'($urandom()));
        send_request(FN_INS_REAR, $urandom(), $urandom(), 5'($urandom()));
        send_request(FN_READ, $urandom(), $urandom(), 5'd16);
        send_request(FN_READ, $urandom(), $urandom(), 5'd17);
        send_request(FN_DELETE, $urandom(), list_copy[LIST_DEPTH-1], 5'($urandom()));
    endtask

    task automatic test_random_traffic(int items, int insert_pct);
        int n;
        int roll;
        logic [31:0] key;
        logic [4:0]  pos;
        for (n = 0; n < items; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < insert_pct) begin
                send_request($urandom_range(0, 1) ? FN_INS_REAR : FN_INS_FRONT,
                             pick_element(), $urandom(), 5'($urandom()));
            end else if (roll < insert_pct + (100 - insert_pct) / 2) begin
                if (held_count > 0 && $urandom_range(0, 3) != 0)
                    key = list_copy[$urandom_range(0, held_count - 1)];
                else
                    key = pick_element();
                send_request(FN_DELETE, $urandom(), key, 5'($urandom()));
            end else begin
                if (held_count > 0 && $urandom_range(0, 4) != 0)
                    pos = 5'($urandom_range(1, held_count));
                else
                    pos = 5'($urandom_range(0, 31));
                send_request(FN_READ, $urandom(), $urandom(), pos);
            end
        end
    endtask

    // hold back new requests until every outstanding result is back
    task automatic test_drain_pause();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    initial begin : run_tests
        int waited;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_list();
        test_edge_values();
        test_fill_to_capacity();
        test_random_traffic(270, 75);
        test_drain_pause();
        test_random_traffic(270, 25);
        steady_send = 1'b1;
        test_random_traffic(270, 50);
        steady_send = 1'b0;
        test_random_traffic(270, 60);
        test_drain_pause();
        test_random_traffic(270, 40);
        s_tvalid <= 1'b0;

        waited = 0;
        while (expected_results.size() != 0 && waited < STALL_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
        if (expected_results.size() != 0) begin
            error_count += expected_results.size();
            $display("%0d results never arrived", expected_results.size());
        end

        if (error_count == 0)
            $display("ordered_list_engine_unit_test: clean");
        else
            $display("ordered_list_engine_unit_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
